>>> design/hkm_pkg.sv
// Shared types and constants for the hash keyed map table.
// Holds the request, status and state codes, the cell command and chain link structs.
// Depends on nothing.

package hkm_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int VALUE_BITS    = 32;
	localparam int KEY_BITS      = 64;
	localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_SET    = 2'd1,
		REQ_DELETE = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_INVALID   = 2'd2,
		STS_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_SEARCH = 2'd1,
		S_COMMIT = 2'd2
	} state_t;

	typedef struct packed {
		logic                  search;
		logic                  commit;
		logic                  invalid;
		logic                  any_hit;
		req_t                  req;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] wval;
	} cell_cmd_t;

	typedef struct packed {
		logic                  free_seen;
		logic                  hit;
		logic [VALUE_BITS-1:0] rd;
	} link_t;

endpackage

>>> design/hash_keyed_map_table.sv
// Top level of the hash keyed map table: request control, result register and the row of cells.
// Depends on hkm_pkg and hkm_cell.
//
// A request transaction on the input channel (req_type, key_digest, write_value) is taken
// when in_valid is high and in_stall is low. Each request gives one result transaction
// (status, found, read_value, entry_count) on the output channel, taken when out_valid is
// high and out_stall is low. A request is captured at accept, compared against every slot
// in the search cycle, and written back in the commit cycle, which also loads the result
// register. The next request can be accepted in the commit cycle, while the last one is
// written back; the pace is set by the search and write-back passes over the row of
// cells. The lowest free slot is claimed by a priority signal that travels along the row.
// While the receiver stalls, the result holds and the commit of a following request waits,
// so at most one request is in flight beside the held result. Reset clears all valid
// marks, the entry count and the handshake state; slot keys are written only when a slot
// is filled, and values when a slot is filled or updated.

module hash_keyed_map_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [63:0] key_digest,
	input  logic [31:0] write_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        found,
	output logic [31:0] read_value,
	output logic [4:0]  entry_count
);

	hkm_pkg::state_t                     state_q;
	hkm_pkg::state_t                     state_d;
	hkm_pkg::req_t                       req_s1;
	logic [hkm_pkg::KEY_BITS-1:0]        key_s1;
	logic [hkm_pkg::VALUE_BITS-1:0]      wval_s1;
	logic                                hit_s2;
	logic                                full_s2;
	logic [hkm_pkg::CNT_BITS-1:0]        cnt_q;
	logic [hkm_pkg::CNT_BITS-1:0]        cnt_d;
	logic                                out_valid_q;
	hkm_pkg::status_t                    status_q;
	hkm_pkg::status_t                    status_d;
	logic                                found_q;
	logic [31:0]                         read_value_q;
	logic [4:0]                          entry_count_q;
	logic                                out_free;
	logic                                in_accept;
	logic                                invalid;
	hkm_pkg::cell_cmd_t                  cmd;
	hkm_pkg::link_t                      link [hkm_pkg::TABLE_ENTRIES+1];

	assign out_free  = ~out_valid_q | ~out_stall;
	assign in_stall  = ~((state_q == hkm_pkg::S_IDLE) ||
	                     (state_q == hkm_pkg::S_COMMIT && out_free));
	assign in_accept = in_valid & ~in_stall;
	assign invalid   = (key_s1 == {hkm_pkg::KEY_BITS{1'b1}});

	always_comb begin
		state_d = state_q;
		case (state_q)
			hkm_pkg::S_IDLE: begin
				if (in_accept) begin
					state_d = hkm_pkg::S_SEARCH;
				end
			end
			hkm_pkg::S_SEARCH: begin
				state_d = hkm_pkg::S_COMMIT;
			end
			hkm_pkg::S_COMMIT: begin
				if (out_free) begin
					state_d = in_accept ? hkm_pkg::S_SEARCH : hkm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = hkm_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.search  = (state_q == hkm_pkg::S_SEARCH);
		cmd.commit  = (state_q == hkm_pkg::S_COMMIT) && out_free;
		cmd.invalid = invalid;
		cmd.any_hit = hit_s2;
		cmd.req     = req_s1;
		cmd.key     = key_s1;
		cmd.wval    = wval_s1;
	end

	assign link[0] = '0;

	for (genvar i = 0; i < hkm_pkg::TABLE_ENTRIES; i++) begin : g_cell
		hkm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.prev   (link[i]),
			.next   (link[i+1])
		);
	end

	always_comb begin
		cnt_d    = cnt_q;
		status_d = hkm_pkg::STS_OK;
		if (invalid) begin
			status_d = hkm_pkg::STS_INVALID;
		end else begin
			case (req_s1)
				hkm_pkg::REQ_SET: begin
					if (!hit_s2) begin
						if (full_s2) begin
							status_d = hkm_pkg::STS_FULL;
						end else begin
							cnt_d = cnt_q + hkm_pkg::CNT_BITS'(1);
						end
					end
				end
				hkm_pkg::REQ_DELETE: begin
					if (hit_s2) begin
						cnt_d = cnt_q - hkm_pkg::CNT_BITS'(1);
					end else begin
						status_d = hkm_pkg::STS_NOT_FOUND;
					end
				end
				default: begin
					if (!hit_s2) begin
						status_d = hkm_pkg::STS_NOT_FOUND;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hkm_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_s1  <= hkm_pkg::req_t'(req_type);
			key_s1  <= key_digest;
			wval_s1 <= hkm_pkg::VALUE_BITS'(write_value);
		end
		if (cmd.search) begin
			hit_s2  <= link[hkm_pkg::TABLE_ENTRIES].hit;
			full_s2 <= ~link[hkm_pkg::TABLE_ENTRIES].free_seen;
		end
		if (cmd.commit) begin
			status_q      <= status_d;
			found_q       <= hit_s2 & ~invalid;
			read_value_q  <= (!invalid && hit_s2 && req_s1 != hkm_pkg::REQ_SET &&
			                  req_s1 != hkm_pkg::REQ_DELETE)
			                 ? 32'(link[hkm_pkg::TABLE_ENTRIES].rd) : '0;
			entry_count_q <= 5'(cnt_d);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found       = found_q;
	assign read_value  = read_value_q;
	assign entry_count = entry_count_q;

	a_search_then_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hkm_pkg::S_SEARCH |=> state_q == hkm_pkg::S_COMMIT)
		else $error("search cycle not followed by commit");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == hkm_pkg::S_COMMIT))
		else $error("result appeared without a commit");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= hkm_pkg::CNT_BITS'(hkm_pkg::TABLE_ENTRIES))
		else $error("entry count above table size");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == hkm_pkg::STS_FULL |->
		cnt_q == hkm_pkg::CNT_BITS'(hkm_pkg::TABLE_ENTRIES))
		else $error("table full reported with free slots");

	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == hkm_pkg::STS_INVALID |-> !found_q && read_value_q == '0)
		else $error("invalid key result carries data");

endmodule

>>> design/hkm_cell.sv
// One slot of the table: key, value and valid mark, with its compare and write logic.
// Passes the free-slot priority, hit and read data on to the next cell of the row.
// Depends on hkm_pkg.

module hkm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  hkm_pkg::cell_cmd_t cmd,
	input  hkm_pkg::link_t     prev,
	output hkm_pkg::link_t     next
);

	logic [hkm_pkg::KEY_BITS-1:0]   key_q;
	logic [hkm_pkg::VALUE_BITS-1:0] value_q;
	logic                           valid_q;
	logic                           hit_q;
	logic                           take_q;
	logic                           match;

	assign match = valid_q && (key_q == cmd.key);

	always_comb begin
		next.free_seen = prev.free_seen | ~valid_q;
		next.hit       = prev.hit | match;
		next.rd        = prev.rd | (hit_q ? value_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
			take_q  <= 1'b0;
		end else begin
			if (cmd.search) begin
				hit_q  <= match;
				take_q <= ~valid_q & ~prev.free_seen;
			end
			if (cmd.commit && !cmd.invalid) begin
				case (cmd.req)
					hkm_pkg::REQ_SET: begin
						if (!cmd.any_hit && take_q) begin
							valid_q <= 1'b1;
						end
					end
					hkm_pkg::REQ_DELETE: begin
						if (hit_q) begin
							valid_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && !cmd.invalid && cmd.req == hkm_pkg::REQ_SET) begin
			if (hit_q) begin
				value_q <= cmd.wval;
			end else if (!cmd.any_hit && take_q) begin
				key_q   <= cmd.key;
				value_q <= cmd.wval;
			end
		end
	end

endmodule
